// ===== design/bdb_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline evaluator package
// Shared constants, payload types and an arithmetic helper.
// ----------------------------------------------------------------------------
package bdb_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DEGREE = 5;
  localparam int VALUE_BITS = 32;
  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int KN_AW      = $clog2(KNOT_DEPTH);
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int ALPHA_W    = 17;
  localparam int FRAC_BITS  = 16;
  localparam int CTRL_W     = 3 * VALUE_BITS;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_KNOT  = 2'd1;
  localparam logic [1:0] KIND_EVAL  = 2'd2;

  localparam logic CFG_DEGREE      = 1'b0;
  localparam logic CFG_POINT_COUNT = 1'b1;

  localparam logic [2:0] DEGREE_RESET = 3'd3;
  localparam logic [6:0] COUNT_RESET  = 7'd4;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [6:0]                   slot;
    logic signed [VALUE_BITS-1:0] coord_x;
    logic signed [VALUE_BITS-1:0] coord_y;
    logic signed [VALUE_BITS-1:0] coord_z;
    logic signed [VALUE_BITS-1:0] knot_value;
    logic signed [VALUE_BITS-1:0] param_u;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] point_x;
    logic signed [VALUE_BITS-1:0] point_y;
    logic signed [VALUE_BITS-1:0] point_z;
    logic                         zero_span;
  } out_t;

  function automatic logic signed [VALUE_BITS-1:0] sat_val(
    input logic signed [VALUE_BITS+3:0] v);
    logic signed [VALUE_BITS+3:0] hi;
    logic signed [VALUE_BITS+3:0] lo;
    hi = (VALUE_BITS+4)'({1'b0, {(VALUE_BITS-1){1'b1}}});
    lo = -hi - (VALUE_BITS+4)'(1);
    if (v > hi) begin
      return hi[VALUE_BITS-1:0];
    end else if (v < lo) begin
      return lo[VALUE_BITS-1:0];
    end
    return v[VALUE_BITS-1:0];
  endfunction

endpackage

// ===== design/bdb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bspline_deboor_eval_top.sv =====
// An evaluation runs a span search, which may stop on a knot compare, then loads the
// p+1 control points and performs p*(p+1)/2 blends; a blend runs a 16-step restoring
// division when its weight lies strictly between zero and one.
// One transaction is in work at a time, and a held result delays the next one.
// Reset (rst_n, synchronous) sets degree 3 and point count 4 and empties the output
// register; the tables hold unknown values until written.
// ----------------------------------------------------------------------------
// B-spline de Boor evaluator top level
// Control point and knot memories with a sequencer for span search and blends.
// ----------------------------------------------------------------------------
module bspline_deboor_eval_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bdb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bdb_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_LO, S_HI, S_CLAMP, S_SRCH_RD, S_SRCH_CHK, S_LOAD,
    S_RB, S_RT, S_ALPHA, S_DIV, S_MUL, S_ACC, S_OUT
  } state_t;

  localparam int VB = bdb_pkg::VALUE_BITS;
  localparam int PW = 2 * VB + 3;

  state_t state_r;
  logic [2:0] degree_r;
  logic [6:0] point_count_r;
  logic [bdb_pkg::PT_AW-1:0] n_r, k_r;
  logic [bdb_pkg::DEG_W-1:0] p_r, j_r, i_r, r_r, ld_idx_r;
  logic ld_v_r;
  logic signed [VB-1:0] u_r, lo_r, ub_r, base_r;
  logic [VB:0] rem_r, den_r;
  logic [bdb_pkg::FRAC_BITS-1:0] q_r;
  logic [3:0] cnt_r;
  logic [bdb_pkg::ALPHA_W-1:0] alpha_r;
  logic zero_r;
  logic signed [VB-1:0] dx_r [bdb_pkg::MAX_DEGREE+1];
  logic signed [VB-1:0] dy_r [bdb_pkg::MAX_DEGREE+1];
  logic signed [VB-1:0] dz_r [bdb_pkg::MAX_DEGREE+1];
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic out_valid_r;
  bdb_pkg::out_t out_r;

  logic accept;
  logic [bdb_pkg::PT_AW-1:0] n_c;
  logic [bdb_pkg::DEG_W-1:0] p_c;
  logic kn_we, ct_we;
  logic [bdb_pkg::KN_AW-1:0] kn_raddr;
  logic [bdb_pkg::PT_AW-1:0] ct_raddr;
  logic [VB-1:0] kn_rdata;
  logic [bdb_pkg::CTRL_W-1:0] ct_rdata;
  logic signed [VB-1:0] kn_q, hi_c, ub_c;
  logic signed [VB:0] num_c, den_c;
  logic [VB+1:0] rem2_c;
  logic signed [VB:0] dfx_c, dfy_c, dfz_c;
  logic signed [bdb_pkg::ALPHA_W:0] alpha_s;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign kn_we = accept && (in_data.kind == bdb_pkg::KIND_KNOT) &&
                 (in_data.slot < 7'(bdb_pkg::KNOT_DEPTH));
  assign ct_we = accept && (in_data.kind == bdb_pkg::KIND_POINT) &&
                 (in_data.slot < 7'(bdb_pkg::MAX_POINTS));

  always_comb begin
    if (point_count_r < 7'd2) begin
      n_c = bdb_pkg::PT_AW'(1);
    end else if (point_count_r > 7'(bdb_pkg::MAX_POINTS)) begin
      n_c = bdb_pkg::PT_AW'(bdb_pkg::MAX_POINTS - 1);
    end else begin
      n_c = bdb_pkg::PT_AW'(point_count_r - 7'd1);
    end
    if (degree_r < 3'd1) begin
      p_c = bdb_pkg::DEG_W'(1);
    end else if (degree_r > 3'(bdb_pkg::MAX_DEGREE)) begin
      p_c = bdb_pkg::DEG_W'(bdb_pkg::MAX_DEGREE);
    end else begin
      p_c = bdb_pkg::DEG_W'(degree_r);
    end
    if (bdb_pkg::PT_AW'(p_c) > n_c) begin
      p_c = bdb_pkg::DEG_W'(n_c);
    end
  end

  always_comb begin
    case (state_r)
      S_LO:      kn_raddr = bdb_pkg::KN_AW'(p_r);
      S_HI:      kn_raddr = bdb_pkg::KN_AW'(n_r) + bdb_pkg::KN_AW'(1);
      S_SRCH_RD: kn_raddr = bdb_pkg::KN_AW'(k_r) + bdb_pkg::KN_AW'(1);
      S_RB:      kn_raddr = bdb_pkg::KN_AW'(i_r) + bdb_pkg::KN_AW'(k_r)
                            - bdb_pkg::KN_AW'(p_r);
      S_RT:      kn_raddr = bdb_pkg::KN_AW'(i_r) + bdb_pkg::KN_AW'(1)
                            + bdb_pkg::KN_AW'(k_r) - bdb_pkg::KN_AW'(r_r);
      default:   kn_raddr = '0;
    endcase
  end

  assign ct_raddr = k_r - bdb_pkg::PT_AW'(p_r) + bdb_pkg::PT_AW'(j_r);

  bdb_ram #(.WIDTH(VB), .DEPTH(bdb_pkg::KNOT_DEPTH)) u_knot_ram (
    .clk   (clk),
    .we    (kn_we),
    .waddr (in_data.slot[bdb_pkg::KN_AW-1:0]),
    .wdata (in_data.knot_value),
    .raddr (kn_raddr),
    .rdata (kn_rdata)
  );

  bdb_ram #(.WIDTH(bdb_pkg::CTRL_W), .DEPTH(bdb_pkg::MAX_POINTS)) u_ctrl_ram (
    .clk   (clk),
    .we    (ct_we),
    .waddr (in_data.slot[bdb_pkg::PT_AW-1:0]),
    .wdata ({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .raddr (ct_raddr),
    .rdata (ct_rdata)
  );

  always_comb begin
    kn_q = $signed(kn_rdata);
    hi_c = kn_q;
    ub_c = u_r;
    if (ub_c < lo_r) begin
      ub_c = lo_r;
    end
    if (ub_c > hi_c) begin
      ub_c = hi_c;
    end
    num_c  = {ub_r[VB-1], ub_r} - {base_r[VB-1], base_r};
    den_c  = {kn_q[VB-1], kn_q} - {base_r[VB-1], base_r};
    rem2_c = {rem_r, 1'b0};
    alpha_s = $signed({1'b0, alpha_r});
    dfx_c = {dx_r[i_r][VB-1], dx_r[i_r]} - {dx_r[i_r-1][VB-1], dx_r[i_r-1]};
    dfy_c = {dy_r[i_r][VB-1], dy_r[i_r]} - {dy_r[i_r-1][VB-1], dy_r[i_r-1]};
    dfz_c = {dz_r[i_r][VB-1], dz_r[i_r]} - {dz_r[i_r-1][VB-1], dz_r[i_r-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      degree_r      <= bdb_pkg::DEGREE_RESET;
      point_count_r <= bdb_pkg::COUNT_RESET;
      out_valid_r   <= 1'b0;
      ld_v_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bdb_pkg::CFG_DEGREE:      degree_r <= cfg_wdata[2:0];
          bdb_pkg::CFG_POINT_COUNT: point_count_r <= cfg_wdata;
          default: ;
        endcase
      end
      out_valid_r <= (state_r == S_OUT) || (out_valid_r && out_stall);
      ld_v_r <= (state_r == S_LOAD);
      if (ld_v_r) begin
        dx_r[ld_idx_r] <= $signed(ct_rdata[3*VB-1:2*VB]);
        dy_r[ld_idx_r] <= $signed(ct_rdata[2*VB-1:VB]);
        dz_r[ld_idx_r] <= $signed(ct_rdata[VB-1:0]);
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_data.kind == bdb_pkg::KIND_EVAL) begin
            u_r     <= in_data.param_u;
            n_r     <= n_c;
            p_r     <= p_c;
            zero_r  <= 1'b0;
            state_r <= S_LO;
          end
        end
        S_LO: state_r <= S_HI;
        S_HI: begin
          lo_r    <= kn_q;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          ub_r    <= ub_c;
          k_r     <= bdb_pkg::PT_AW'(p_r);
          state_r <= S_SRCH_RD;
        end
        S_SRCH_RD: begin
          j_r <= '0;
          if (k_r < n_r) begin
            state_r <= S_SRCH_CHK;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_SRCH_CHK: begin
          if (kn_q < ub_r) begin
            k_r     <= k_r + bdb_pkg::PT_AW'(1);
            state_r <= S_SRCH_RD;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          ld_idx_r <= j_r;
          if (j_r == p_r) begin
            i_r     <= p_r;
            r_r     <= bdb_pkg::DEG_W'(1);
            state_r <= S_RB;
          end else begin
            j_r <= j_r + bdb_pkg::DEG_W'(1);
          end
        end
        S_RB: state_r <= S_RT;
        S_RT: begin
          base_r  <= kn_q;
          state_r <= S_ALPHA;
        end
        S_ALPHA: begin
          if (den_c <= 0) begin
            zero_r  <= 1'b1;
            alpha_r <= '0;
            state_r <= S_MUL;
          end else if (num_c <= 0) begin
            alpha_r <= '0;
            state_r <= S_MUL;
          end else if (num_c >= den_c) begin
            alpha_r <= bdb_pkg::ALPHA_W'(1 << bdb_pkg::FRAC_BITS);
            state_r <= S_MUL;
          end else begin
            rem_r   <= num_c;
            den_r   <= den_c;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2_c >= {1'b0, den_r}) begin
            rem_r <= VB'(rem2_c - {1'b0, den_r}) | (VB+1)'(0);
            q_r   <= {q_r[bdb_pkg::FRAC_BITS-2:0], 1'b1};
            if (cnt_r == 4'd15) begin
              alpha_r <= {1'b0, q_r[bdb_pkg::FRAC_BITS-2:0], 1'b1};
            end
          end else begin
            rem_r <= rem2_c[VB:0];
            q_r   <= {q_r[bdb_pkg::FRAC_BITS-2:0], 1'b0};
            if (cnt_r == 4'd15) begin
              alpha_r <= {1'b0, q_r[bdb_pkg::FRAC_BITS-2:0], 1'b0};
            end
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= PW'(alpha_s * dfx_c);
          py_r    <= PW'(alpha_s * dfy_c);
          pz_r    <= PW'(alpha_s * dfz_c);
          state_r <= S_ACC;
        end
        S_ACC: begin
          dx_r[i_r] <= bdb_pkg::sat_val((VB+4)'(dx_r[i_r-1])
                       + (VB+4)'((px_r + PW'(32768)) >>> bdb_pkg::FRAC_BITS));
          dy_r[i_r] <= bdb_pkg::sat_val((VB+4)'(dy_r[i_r-1])
                       + (VB+4)'((py_r + PW'(32768)) >>> bdb_pkg::FRAC_BITS));
          dz_r[i_r] <= bdb_pkg::sat_val((VB+4)'(dz_r[i_r-1])
                       + (VB+4)'((pz_r + PW'(32768)) >>> bdb_pkg::FRAC_BITS));
          if (i_r == r_r) begin
            if (r_r == p_r) begin
              state_r <= S_OUT;
            end else begin
              r_r     <= r_r + bdb_pkg::DEG_W'(1);
              i_r     <= p_r;
              state_r <= S_RB;
            end
          end else begin
            i_r     <= i_r - bdb_pkg::DEG_W'(1);
            state_r <= S_RB;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r.point_x   <= dx_r[p_r];
            out_r.point_y   <= dy_r[p_r];
            out_r.point_z   <= dz_r[p_r];
            out_r.zero_span <= zero_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (alpha_r <= bdb_pkg::ALPHA_W'(1 << bdb_pkg::FRAC_BITS)))
    else $error("blend weight above one");
  a_blend_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (i_r >= r_r && r_r >= bdb_pkg::DEG_W'(1) && i_r <= p_r))
    else $error("blend index out of range");
  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (k_r >= bdb_pkg::PT_AW'(p_r) && k_r <= n_r))
    else $error("knot span out of range");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || !out_stall)) |=> (out_valid && state_r == S_IDLE))
    else $error("result transaction not issued");
`endif

endmodule
